// ----- src/slxfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slxfr_pkg - shared types and constants of the frame receiver
// Status codes, register indexes and the link status strings.
// ----------------------------------------------------------------------------
package slxfr_pkg;

  // Seven characters of a link status string, entry 0 is the first one sent
  typedef logic [6:0][7:0] pattern_t;

  typedef enum logic [1:0] {
    STAT_NONE   = 2'd0,
    STAT_GOOD   = 2'd1,
    STAT_CFG_OK = 2'd2,
    STAT_BAD    = 2'd3
  } frame_status_t;

  typedef enum logic [2:0] {
    CFG_FIRST_SYNC  = 3'd0,
    CFG_SECOND_SYNC = 3'd1,
    CFG_GENERIC_TYP = 3'd2,
    CFG_CONFIG_LEN  = 3'd3,
    CFG_GAP_TIMEOUT = 3'd4
  } cfg_index_t;

  localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd500;

  localparam logic [2:0] MATCH_LAST = 3'd6;
  localparam logic [7:0] CHAR_O     = 8'h4F;

  // "OK+CONN" and "OK+LOST", written last character first
  localparam pattern_t CONN_TEXT = {8'h4E, 8'h4E, 8'h4F, 8'h43, 8'h2B, 8'h4B, 8'h4F};
  localparam pattern_t LOST_TEXT = {8'h54, 8'h53, 8'h4F, 8'h4C, 8'h2B, 8'h4B, 8'h4F};

  function automatic logic [7:0] char_at(input pattern_t p, input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = p[0];
      3'd1: ch = p[1];
      3'd2: ch = p[2];
      3'd3: ch = p[3];
      3'd4: ch = p[4];
      3'd5: ch = p[5];
      3'd6: ch = p[6];
      default: ch = p[0];
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- src/sync_length_xor_frame_receiver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver - byte stream deframer with link status
// Accepts one received byte per item with its arrival time and returns one
// result item per byte. It takes one item every clock cycle, and only a
// stalled out_ready holds the pipe; an item's result is on the outputs once
// it has passed the input register and then the result register.
// Frames are two sync bytes, a
// type, a length L, L payload bytes and an XOR checksum over type, length and
// payload. A gap longer than gap_timeout_ms drops a partial frame. Each payload
// byte is reported with its index; the checksum byte reports a verdict (good,
// generic frame of the configured length accepted despite a bad checksum, or
// bad). The frame position wraps at POSITION_WRAP, so payloads with
// L + 5 > POSITION_WRAP never complete. Two matchers watch the raw stream for
// "OK+CONN" and "OK+LOST" and set or clear the connected flag. Write the
// configuration registers only while no item is in flight.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_receiver #(
  parameter int POSITION_WRAP = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [31:0] in_now_ms,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_link_connected,
  output logic             out_payload_valid,
  output logic [7:0]       out_payload_index,
  output logic [7:0]       out_payload_byte,
  output logic             out_frame_end,
  output logic [1:0]       out_frame_status,
  output logic [7:0]       out_frame_type,
  output logic [7:0]       out_frame_length,
  output logic [7:0]       out_computed_checksum,
  output logic [7:0]       out_received_checksum,
  // configuration port
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import slxfr_pkg::*;

  localparam logic [8:0] WRAP_POS = 9'(POSITION_WRAP);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  first_sync_r;
  logic [7:0]  second_sync_r;
  logic [7:0]  generic_type_r;
  logic [7:0]  config_len_r;
  logic [15:0] gap_timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r   <= 8'd0;
      second_sync_r  <= 8'd0;
      generic_type_r <= 8'd0;
      config_len_r   <= 8'd0;
      gap_timeout_r  <= GAP_TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FIRST_SYNC:  first_sync_r   <= cfg_wdata[7:0];
        CFG_SECOND_SYNC: second_sync_r  <= cfg_wdata[7:0];
        CFG_GENERIC_TYP: generic_type_r <= cfg_wdata[7:0];
        CFG_CONFIG_LEN:  config_len_r   <= cfg_wdata[7:0];
        CFG_GAP_TIMEOUT: gap_timeout_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipe control: input register feeds the result register.
  // Advance when the input register holds an item and the result slot is free
  // or being drained this cycle.
  // --------------------------------------------------------------------------
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic [31:0] in_now_r;
  logic       advance;

  assign advance  = in_valid_r && (!out_valid || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload of the input register: load on every accepted item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
      in_now_r  <= in_now_ms;
    end
  end

  // --------------------------------------------------------------------------
  // Link status matchers; LOST acts after CONN on the same byte
  // --------------------------------------------------------------------------
  logic conn_hit;
  logic lost_hit;

  slxfr_matcher u_conn_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .pattern (CONN_TEXT),
    .hit     (conn_hit)
  );

  slxfr_matcher u_lost_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .pattern (LOST_TEXT),
    .hit     (lost_hit)
  );

  // --------------------------------------------------------------------------
  // Frame state
  // --------------------------------------------------------------------------
  logic [7:0]  bpos_r;
  logic [7:0]  bpos_nxt;
  logic [7:0]  len_r;
  logic [7:0]  len_nxt;
  logic [7:0]  type_r;
  logic [7:0]  type_nxt;
  logic [7:0]  csum_r;
  logic [7:0]  csum_nxt;
  logic [31:0] last_ms_r;
  logic        conn_r;
  logic        conn_nxt;

  logic [31:0] elapsed;
  logic        timed_out;
  logic [8:0]  pos;
  logic [8:0]  pos_end;
  logic [8:0]  pos_upd;
  logic [8:0]  len9;

  // result values for this item
  logic        pv_nxt;
  logic [7:0]  pidx_nxt;
  logic [7:0]  pbyte_nxt;
  logic        fend_nxt;
  frame_status_t fstat_nxt;
  logic [7:0]  ftype_nxt;
  logic [7:0]  flen_nxt;
  logic [7:0]  fcalc_nxt;
  logic [7:0]  frecv_nxt;

  assign elapsed   = in_now_r - last_ms_r;
  assign timed_out = (bpos_r != 8'd0) && (elapsed > {16'd0, gap_timeout_r});
  assign pos       = timed_out ? 9'd1 : ({1'b0, bpos_r} + 9'd1);
  assign len9      = {1'b0, len_r};
  assign pos_end   = len9 + 9'd5;

  always_comb begin
    conn_nxt = conn_r;
    if (conn_hit) begin
      conn_nxt = 1'b1;
    end
    if (lost_hit) begin
      conn_nxt = 1'b0;
    end
  end

  always_comb begin
    pos_upd   = pos;
    len_nxt   = len_r;
    type_nxt  = type_r;
    csum_nxt  = csum_r;
    pv_nxt    = 1'b0;
    pidx_nxt  = 8'd0;
    pbyte_nxt = 8'd0;
    fend_nxt  = 1'b0;
    fstat_nxt = STAT_NONE;
    ftype_nxt = 8'd0;
    flen_nxt  = 8'd0;
    fcalc_nxt = 8'd0;
    frecv_nxt = 8'd0;
    if (pos == 9'd1) begin
      if (in_byte_r != first_sync_r) begin
        pos_upd = 9'd0;
      end
    end else if (pos == 9'd2) begin
      if (in_byte_r != second_sync_r) begin
        pos_upd = 9'd0;
      end
    end else if (pos == 9'd3) begin
      type_nxt = in_byte_r;
      csum_nxt = in_byte_r;
    end else if (pos == 9'd4) begin
      len_nxt  = in_byte_r;
      csum_nxt = csum_r ^ in_byte_r;
    end else if (pos == pos_end) begin
      // checksum byte: give the verdict and go idle
      fend_nxt  = 1'b1;
      ftype_nxt = type_r;
      flen_nxt  = len_r;
      fcalc_nxt = csum_r;
      frecv_nxt = in_byte_r;
      if (csum_r == in_byte_r) begin
        fstat_nxt = STAT_GOOD;
      end else if (type_r == generic_type_r && len_r == config_len_r) begin
        fstat_nxt = STAT_CFG_OK;
      end else begin
        fstat_nxt = STAT_BAD;
      end
      pos_upd = 9'd0;
    end else if (pos < pos_end) begin
      pv_nxt    = 1'b1;
      pidx_nxt  = 8'(pos - 9'd5);
      pbyte_nxt = in_byte_r;
      csum_nxt  = csum_r ^ in_byte_r;
    end
    // drop the frame once the position reaches the wrap point
    if (pos_upd >= WRAP_POS) begin
      pos_upd = 9'd0;
    end
    bpos_nxt = pos_upd[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r    <= 8'd0;
      len_r     <= 8'd0;
      type_r    <= 8'd0;
      csum_r    <= 8'd0;
      last_ms_r <= 32'd0;
      conn_r    <= 1'b0;
    end else if (advance) begin
      bpos_r    <= bpos_nxt;
      len_r     <= len_nxt;
      type_r    <= type_nxt;
      csum_r    <= csum_nxt;
      last_ms_r <= in_now_r;
      conn_r    <= conn_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold while the consumer stalls
  // --------------------------------------------------------------------------
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_link_connected    <= conn_nxt;
      out_payload_valid     <= pv_nxt;
      out_payload_index     <= pidx_nxt;
      out_payload_byte      <= pbyte_nxt;
      out_frame_end         <= fend_nxt;
      out_frame_status      <= fstat_nxt;
      out_frame_type        <= ftype_nxt;
      out_frame_length      <= flen_nxt;
      out_computed_checksum <= fcalc_nxt;
      out_received_checksum <= frecv_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- src/slxfr_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slxfr_matcher - status string matcher
// Tracks progress through a seven character string over the raw byte stream.
// ----------------------------------------------------------------------------
module slxfr_matcher (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [7:0]         rx_byte,
  input  wire slxfr_pkg::pattern_t pattern,
  output logic                    hit
);
  import slxfr_pkg::*;

  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;

  // On a miss restart at one if the byte opens the string again
  always_comb begin
    hit     = 1'b0;
    cnt_nxt = cnt_r;
    if (rx_byte == char_at(pattern, cnt_r)) begin
      if (cnt_r == MATCH_LAST) begin
        hit     = 1'b1;
        cnt_nxt = 3'd0;
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end else begin
      cnt_nxt = (rx_byte == pattern[0]) ? 3'd1 : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/slxfr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slxfr_checker - port level checks of the frame receiver
// Watches the result channel for consistent verdicts and payload reports.
// ----------------------------------------------------------------------------
module slxfr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_payload_valid,
  input wire logic [7:0]  out_payload_index,
  input wire logic [7:0]  out_payload_byte,
  input wire logic        out_frame_end,
  input wire logic [1:0]  out_frame_status,
  input wire logic [7:0]  out_frame_type,
  input wire logic [7:0]  out_computed_checksum,
  input wire logic [7:0]  out_received_checksum
);
  import slxfr_pkg::*;

  // stalled result holds its verdict
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_status))
    else $error("result changed while stalled");

  // a byte is payload or checksum, never both
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_payload_valid && out_frame_end))
    else $error("payload and frame end together");

  // no verdict without a frame end
  a_nostat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |->
      out_frame_status == STAT_NONE && out_frame_type == 8'd0)
    else $error("verdict without frame end");

  // good verdict means matching checksums, a mismatch never reads good
  a_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |->
      ((out_frame_status == STAT_GOOD) == (out_computed_checksum == out_received_checksum)))
    else $error("verdict disagrees with checksums");

  // idle payload fields read zero
  a_pzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |->
      out_payload_index == 8'd0 && out_payload_byte == 8'd0)
    else $error("payload fields set without payload");

endmodule

bind sync_length_xor_frame_receiver slxfr_checker u_slxfr_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_payload_valid     (out_payload_valid),
  .out_payload_index     (out_payload_index),
  .out_payload_byte      (out_payload_byte),
  .out_frame_end         (out_frame_end),
  .out_frame_status      (out_frame_status),
  .out_frame_type        (out_frame_type),
  .out_computed_checksum (out_computed_checksum),
  .out_received_checksum (out_received_checksum)
);
`default_nettype wire
